@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in the same cycle as the consequent
`define MRP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define MRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/mrp_pkg.sv @@
// Shared constants, types and functions of the primality tester
package mrp_pkg;

  localparam int DATA_W    = 64;
  localparam int WORD_BITS = 64;
  localparam int CNT_W     = $clog2(DATA_W);
  localparam int IDX_W     = 4;

  localparam logic [DATA_W-1:0] CAND_MASK = {DATA_W{1'b1}} >> (DATA_W - WORD_BITS);

  localparam logic [DATA_W-1:0] LIM_SMALL = 64'd9080191;
  localparam logic [DATA_W-1:0] LIM_MID   = 64'd4759123141;
  localparam logic [DATA_W-1:0] LIM_BIG   = 64'd1122004669633;
  localparam logic [DATA_W-1:0] LIM_W6    = 64'd2152302898747;
  localparam logic [DATA_W-1:0] LIM_W7    = 64'd3474749660383;
  localparam logic [DATA_W-1:0] LIM_W9    = 64'd341550071728321;
  localparam logic [DATA_W-1:0] LIM_W12   = 64'd3825123056546413051;
  localparam logic [DATA_W-1:0] PRIME_31  = 64'd31;
  localparam logic [DATA_W-1:0] PRIME_73  = 64'd73;

  localparam logic [1:0] SET_SMALL = 2'd0;
  localparam logic [1:0] SET_MID   = 2'd1;
  localparam logic [1:0] SET_BIG   = 2'd2;
  localparam logic [1:0] SET_WIDE  = 2'd3;

  localparam logic [1:0] MUL_RB = 2'd0; // r = r*b
  localparam logic [1:0] MUL_BB = 2'd1; // b = b*b
  localparam logic [1:0] MUL_RR = 2'd2; // r = r*r

  typedef struct packed {
    logic       load;
    logic       decomp_init;
    logic       shift;
    logic       base_load;
    logic       reduce;
    logic       e_shift;
    logic       mul_start;
    logic [1:0] mul_op;
    logic       rr_init;
    logic       rr_inc;
    logic       idx_inc;
  } cmd_t;

  typedef struct packed {
    logic lt2;
    logic eq2;
    logic even;
    logic direct;
    logic d_even;
    logic b_ge_n;
    logic e_zero;
    logic e_lsb;
    logic mul_done;
    logic x_one;
    logic x_nm1;
    logic rr_lt_s;
    logic idx_last;
  } sts_t;

  function automatic logic [DATA_W-1:0] add_mod(input logic [DATA_W-1:0] x,
                                               input logic [DATA_W-1:0] y,
                                               input logic [DATA_W-1:0] n);
    logic [DATA_W-1:0] room;
    room = n - y;
    return (x >= room) ? (x - room) : (x + y);
  endfunction

  function automatic logic [DATA_W-1:0] base_of(input logic [1:0] set,
                                               input logic [IDX_W-1:0] idx);
    logic [20:0] b;
    b = 21'd2;
    case (set)
      SET_SMALL: b = (idx == 4'd0) ? 21'd31 : 21'd73;
      SET_MID: begin
        case (idx)
          4'd0:    b = 21'd7;
          4'd1:    b = 21'd2;
          default: b = 21'd61;
        endcase
      end
      SET_BIG: begin
        case (idx)
          4'd0:    b = 21'd13;
          4'd1:    b = 21'd2;
          4'd2:    b = 21'd23;
          default: b = 21'd1662803;
        endcase
      end
      default: begin
        case (idx)
          4'd0:    b = 21'd11;
          4'd1:    b = 21'd7;
          4'd2:    b = 21'd5;
          4'd3:    b = 21'd3;
          4'd4:    b = 21'd2;
          4'd5:    b = 21'd13;
          4'd6:    b = 21'd17;
          4'd7:    b = 21'd19;
          4'd8:    b = 21'd23;
          4'd9:    b = 21'd29;
          4'd10:   b = 21'd31;
          default: b = 21'd37;
        endcase
      end
    endcase
    return {{(DATA_W-21){1'b0}}, b};
  endfunction

endpackage

@@ hdl/mrp_if.sv @@
// Valid/ready channel interfaces for candidates and verdicts
interface mrp_in_if;
  logic                      valid;
  logic                      ready;
  logic [mrp_pkg::DATA_W-1:0] candidate;
  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

interface mrp_out_if;
  logic valid;
  logic ready;
  logic is_prime;
  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface

@@ hdl/mrp_mulmod.sv @@
// Bit-serial modular multiplier: double-and-add, at most one modular add per cycle
`include "assert_macros.svh"
module mrp_mulmod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mrp_pkg::DATA_W-1:0] a,
  input  logic [mrp_pkg::DATA_W-1:0] b,
  input  logic [mrp_pkg::DATA_W-1:0] n,
  output logic                       done,
  output logic [mrp_pkg::DATA_W-1:0] res
);

  logic                       busy_r, busy_nxt;
  logic                       phase_r, phase_nxt;
  logic                       done_r, done_nxt;
  logic [mrp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [mrp_pkg::DATA_W-1:0] acc_r, acc_nxt;
  logic [mrp_pkg::DATA_W-1:0] a_r, a_nxt;
  logic [mrp_pkg::DATA_W-1:0] b_r, b_nxt;
  logic [mrp_pkg::DATA_W-1:0] n_r, n_nxt;
  logic [mrp_pkg::DATA_W-1:0] add_y;

  assign add_y = phase_r ? a_r : acc_r;

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    n_nxt     = n_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt  = 1'b1;
        phase_nxt = 1'b0;
        cnt_nxt   = '1;
        acc_nxt   = '0;
        a_nxt     = a;
        b_nxt     = b;
        n_nxt     = n;
      end
    end else if (!phase_r) begin
      acc_nxt   = mrp_pkg::add_mod(acc_r, add_y, n_r);
      phase_nxt = 1'b1;
    end else begin
      if (b_r[mrp_pkg::DATA_W-1]) begin
        acc_nxt = mrp_pkg::add_mod(acc_r, add_y, n_r);
      end
      b_nxt     = b_r << 1;
      phase_nxt = 1'b0;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    n_r   <= n_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;

  `MRP_ASSERT_SAME(a_res_reduced, done_r, acc_r < n_r)
  `MRP_ASSERT_NEXT(a_start_busy, start && !busy_r, busy_r)

endmodule

@@ hdl/mrp_dp.sv @@
// Datapath: candidate, exponent, accumulators, base selection and multiplier
module mrp_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mrp_pkg::DATA_W-1:0] candidate,
  input  mrp_pkg::cmd_t              cmd,
  output mrp_pkg::sts_t              sts
);

  logic [mrp_pkg::DATA_W-1:0] n_r, d_r, b_r, e_r, r_r;
  logic [mrp_pkg::CNT_W-1:0]  s_r, rr_r;
  logic [mrp_pkg::IDX_W-1:0]  idx_r, last_r;
  logic [1:0]                 set_r, op_r;
  logic [1:0]                 set_nxt;
  logic [mrp_pkg::IDX_W-1:0]  last_nxt;
  logic [mrp_pkg::DATA_W-1:0] nm1;
  logic [mrp_pkg::DATA_W-1:0] mul_a, mul_b, mul_res;
  logic                       mul_done;

  assign nm1 = n_r - 1'b1;

  always_comb begin
    if (n_r < mrp_pkg::LIM_SMALL) begin
      set_nxt = mrp_pkg::SET_SMALL; last_nxt = 4'd1;
    end else if (n_r < mrp_pkg::LIM_MID) begin
      set_nxt = mrp_pkg::SET_MID;   last_nxt = 4'd2;
    end else if (n_r < mrp_pkg::LIM_BIG) begin
      set_nxt = mrp_pkg::SET_BIG;   last_nxt = 4'd3;
    end else begin
      set_nxt = mrp_pkg::SET_WIDE;
      if (n_r < mrp_pkg::LIM_W6)       last_nxt = 4'd4;
      else if (n_r < mrp_pkg::LIM_W7)  last_nxt = 4'd5;
      else if (n_r < mrp_pkg::LIM_W9)  last_nxt = 4'd6;
      else if (n_r < mrp_pkg::LIM_W12) last_nxt = 4'd8;
      else                             last_nxt = 4'd11;
    end
  end

  always_comb begin
    case (cmd.mul_op)
      mrp_pkg::MUL_RB: begin mul_a = r_r; mul_b = b_r; end
      mrp_pkg::MUL_BB: begin mul_a = b_r; mul_b = b_r; end
      default:         begin mul_a = r_r; mul_b = r_r; end
    endcase
  end

  mrp_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .n     (n_r),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.load)        n_r <= candidate & mrp_pkg::CAND_MASK;
    if (cmd.decomp_init) begin
      d_r    <= nm1;
      s_r    <= '0;
      idx_r  <= '0;
      set_r  <= set_nxt;
      last_r <= last_nxt;
    end
    if (cmd.shift) begin
      d_r <= d_r >> 1;
      s_r <= s_r + 1'b1;
    end
    if (cmd.base_load) begin
      b_r <= mrp_pkg::base_of(set_r, idx_r);
      e_r <= d_r;
      r_r <= {{(mrp_pkg::DATA_W-1){1'b0}}, 1'b1};
    end
    if (cmd.reduce)    b_r <= b_r - n_r;
    if (cmd.e_shift)   e_r <= e_r >> 1;
    if (cmd.mul_start) op_r <= cmd.mul_op;
    if (mul_done) begin
      if (op_r == mrp_pkg::MUL_BB) b_r <= mul_res;
      else                          r_r <= mul_res;
    end
    if (cmd.rr_init) rr_r <= {{(mrp_pkg::CNT_W-1){1'b0}}, 1'b1};
    if (cmd.rr_inc)  rr_r <= rr_r + 1'b1;
    if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
  end

  always_comb begin
    sts.lt2      = n_r < 64'd2;
    sts.eq2      = n_r == 64'd2;
    sts.even     = !n_r[0];
    sts.direct   = (n_r == mrp_pkg::PRIME_31) || (n_r == mrp_pkg::PRIME_73);
    sts.d_even   = !d_r[0];
    sts.b_ge_n   = b_r >= n_r;
    sts.e_zero   = e_r == '0;
    sts.e_lsb    = e_r[0];
    sts.mul_done = mul_done;
    sts.x_one    = r_r == {{(mrp_pkg::DATA_W-1){1'b0}}, 1'b1};
    sts.x_nm1    = r_r == nm1;
    sts.rr_lt_s  = rr_r < s_r;
    sts.idx_last = idx_r == last_r;
  end

endmodule

@@ hdl/mrp_ctrl.sv @@
// Controller: sequences decomposition, exponentiation and witness rounds
`include "assert_macros.svh"
module mrp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_is_prime,
  output mrp_pkg::cmd_t cmd,
  input  mrp_pkg::sts_t sts
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLASS  = 4'd1;
  localparam logic [3:0] S_SHIFT  = 4'd2;
  localparam logic [3:0] S_BASE   = 4'd3;
  localparam logic [3:0] S_REDUCE = 4'd4;
  localparam logic [3:0] S_POW    = 4'd5;
  localparam logic [3:0] S_MUL_RB = 4'd6;
  localparam logic [3:0] S_SQB    = 4'd7;
  localparam logic [3:0] S_MUL_BB = 4'd8;
  localparam logic [3:0] S_CHECK  = 4'd9;
  localparam logic [3:0] S_WLOOP  = 4'd10;
  localparam logic [3:0] S_MUL_RR = 4'd11;
  localparam logic [3:0] S_WTEST  = 4'd12;
  localparam logic [3:0] S_NEXT   = 4'd13;
  localparam logic [3:0] S_FIN    = 4'd14;

  logic [3:0] st_r, st_nxt;
  logic       verdict_r, verdict_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       prime_r, prime_nxt;

  assign in_ready     = st_r == S_IDLE;
  assign out_valid    = out_valid_r;
  assign out_is_prime = prime_r;

  always_comb begin
    st_nxt        = st_r;
    verdict_nxt   = verdict_r;
    out_valid_nxt = out_valid_r && !out_ready;
    prime_nxt     = prime_r;
    cmd           = '0;
    cmd.mul_op    = mrp_pkg::MUL_RB;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          st_nxt   = S_CLASS;
        end
      end
      S_CLASS: begin
        if (sts.lt2) begin
          verdict_nxt = 1'b0; st_nxt = S_FIN;
        end else if (sts.eq2) begin
          verdict_nxt = 1'b1; st_nxt = S_FIN;
        end else if (sts.even) begin
          verdict_nxt = 1'b0; st_nxt = S_FIN;
        end else begin
          cmd.decomp_init = 1'b1;
          st_nxt          = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // 31 and 73 fall in the small range and answer at once
        if (sts.direct) begin
          verdict_nxt = 1'b1; st_nxt = S_FIN;
        end else if (sts.d_even) cmd.shift = 1'b1;
        else st_nxt = S_BASE;
      end
      S_BASE: begin
        cmd.base_load = 1'b1;
        st_nxt        = S_REDUCE;
      end
      S_REDUCE: begin
        if (sts.b_ge_n) cmd.reduce = 1'b1;
        else st_nxt = S_POW;
      end
      S_POW: begin
        if (sts.e_zero) st_nxt = S_CHECK;
        else if (sts.e_lsb) begin
          cmd.mul_start = 1'b1; cmd.mul_op = mrp_pkg::MUL_RB; st_nxt = S_MUL_RB;
        end else begin
          cmd.mul_start = 1'b1; cmd.mul_op = mrp_pkg::MUL_BB; st_nxt = S_MUL_BB;
        end
      end
      S_MUL_RB: if (sts.mul_done) st_nxt = S_SQB;
      S_SQB: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = mrp_pkg::MUL_BB;
        st_nxt        = S_MUL_BB;
      end
      S_MUL_BB: begin
        if (sts.mul_done) begin
          cmd.e_shift = 1'b1;
          st_nxt      = S_POW;
        end
      end
      S_CHECK: begin
        if (sts.x_one || sts.x_nm1) st_nxt = S_NEXT;
        else begin
          cmd.rr_init = 1'b1;
          st_nxt      = S_WLOOP;
        end
      end
      S_WLOOP: begin
        if (sts.rr_lt_s) begin
          cmd.mul_start = 1'b1; cmd.mul_op = mrp_pkg::MUL_RR; st_nxt = S_MUL_RR;
        end else begin
          verdict_nxt = 1'b0; st_nxt = S_FIN;
        end
      end
      S_MUL_RR: if (sts.mul_done) st_nxt = S_WTEST;
      S_WTEST: begin
        if (sts.x_one) begin
          verdict_nxt = 1'b0; st_nxt = S_FIN;
        end else if (sts.x_nm1) st_nxt = S_NEXT;
        else begin
          cmd.rr_inc = 1'b1;
          st_nxt     = S_WLOOP;
        end
      end
      S_NEXT: begin
        if (sts.idx_last) begin
          verdict_nxt = 1'b1; st_nxt = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          st_nxt      = S_BASE;
        end
      end
      S_FIN: begin
        // hold the verdict until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          prime_nxt     = verdict_r;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
    verdict_r <= verdict_nxt;
    prime_r   <= prime_nxt;
  end

  `MRP_ASSERT_NEXT(a_accept_class, in_valid && in_ready, st_r == S_CLASS)
  `MRP_ASSERT_SAME(a_done_in_mul, sts.mul_done,
                   st_r == S_MUL_RB || st_r == S_MUL_BB || st_r == S_MUL_RR)

endmodule

@@ hdl/miller_rabin_prime_test_64.sv @@
// Top level of the deterministic 64-bit Miller-Rabin primality tester
// Usage:
//  - in_ch carries one 64-bit candidate per beat; out_ch returns one verdict
//    beat (is_prime) per candidate, in order.
//  - One candidate is worked on at a time; in_ch.ready is high only while
//    the controller is idle.
//  - Trivial cases are decided in S_CLASS (below 2, even) or S_SHIFT (31, 73)
//    and go straight to S_FIN without exponentiation.
//  - Otherwise each modular multiply runs in the bit-serial multiplier
//    (up to two modular adds per operand bit). A set exponent bit costs a
//    multiply by the base and a squaring of it, a clear one only the
//    squaring; each witness round costs a squaring. Exponent bits plus
//    squarings stay within 64 per base, with up to twelve bases per
//    candidate.
//  - The multiplier is the bottleneck; the other steps run in the controller.
//  - A finished verdict sits in an output register; a new candidate is taken
//    while it waits. If the receiver stalls, the next verdict waits in the
//    controller until the register drains.
//  - Synchronous active-low reset returns to idle with no verdict pending.
module miller_rabin_prime_test_64 (
  input  logic      clk,
  input  logic      rst_n,
  mrp_in_if.sink    in_ch,
  mrp_out_if.source out_ch
);

  mrp_pkg::cmd_t cmd;
  mrp_pkg::sts_t sts;

  mrp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_is_prime (out_ch.is_prime),
    .cmd          (cmd),
    .sts          (sts)
  );

  mrp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .candidate (in_ch.candidate),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
